// File: rtl/pcfs_pkg.sv
`default_nettype none
package pcfs_pkg;

   // register indexes on the csr port
   localparam logic [2:0] CSR_RESET_CODE  = 3'd0;
   localparam logic [2:0] CSR_SYNC_CODE   = 3'd1;
   localparam logic [2:0] CSR_START_CODE  = 3'd2;
   localparam logic [2:0] CSR_RESET_DELAY = 3'd3;
   localparam logic [2:0] CSR_SYNC_IDLE   = 3'd4;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 12;

   // register reset values
   localparam logic [3:0]  RESET_CODE_DEF  = 4'd4;
   localparam logic [3:0]  SYNC_CODE_DEF   = 4'd1;
   localparam logic [3:0]  START_CODE_DEF  = 4'd2;
   localparam logic [11:0] RESET_DELAY_DEF = 12'd1;
   localparam logic [11:0] SYNC_IDLE_DEF   = 12'd1;

   // input item kinds
   localparam logic KIND_START = 1'b0;
   localparam logic KIND_BYTE  = 1'b1;

   // line symbols
   localparam logic [1:0] SYM_ZERO  = 2'd0;
   localparam logic [1:0] SYM_ONE   = 2'd1;
   localparam logic [1:0] SYM_DELAY = 2'd2;
   localparam logic [1:0] SYM_IDLE  = 2'd3;

   localparam logic [11:0] HDR_RUN  = 12'd15;
   localparam logic [11:0] ONE_RUN  = 12'd1;
   localparam logic [3:0]  CMD_MSB  = 4'd3;
   localparam logic [3:0]  DATA_MSB = 4'd11;

   // b*4095/255 = 16*b + b/17, and b/17 = (b*241) >> 12 for every byte
   localparam int SCALE_RECIP = 241;
   localparam int SCALE_SHIFT = 12;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic       kind;
      logic       need_reset;
      logic [7:0] level;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic [1:0]  symbol;
      logic [11:0] repeat_res;
      logic        run_last;
      logic        frame_end;
   } rsp_type;

   typedef struct packed {
      logic [3:0]  reset_code;
      logic [3:0]  sync_code;
      logic [3:0]  start_code;
      logic [11:0] reset_delay_count;
      logic [11:0] sync_idle_count;
   } cfg_type;

   // classified work item handed from front to back
   typedef struct packed {
      logic        is_start;
      logic        do_reset;
      logic [11:0] value;
      logic        last;
   } qent_type;

   function automatic logic [11:0] scale_level(input logic [7:0] level);
      logic [15:0] prod;
      prod = 16'(level) * 16'(SCALE_RECIP);
      return {level, 4'b0000} + 12'(prod[15:SCALE_SHIFT]);
   endfunction

endpackage
`default_nettype wire

// File: rtl/pixel_chain_frame_serializer_unit.sv
// path: item to queue entry, then to the back's state register, then its results to the rsp register
// throughput: one result transfer per cycle while rsp_stall is low; a channel byte gives 13 results;
//    a start item gives 11 to 18 results depending on the reset path and the nonzero run counts
// the 4-entry queue absorbs items so the input keeps moving while one is serialized, until the queue is full
// reset: synchronous, active high; clears queue, frame state and rsp_valid, loads register defaults
`default_nettype none
module pixel_chain_frame_serializer_unit (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  req_valid,
   output logic                                 req_stall,
   input  pcfs_pkg::req_type                    req_data,
   output logic                                 rsp_valid,
   input  wire                                  rsp_stall,
   output pcfs_pkg::rsp_type                    rsp_data,
   input  wire                                  csr_write,
   input  wire [pcfs_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  wire [pcfs_pkg::CSR_DATA_W-1:0]       csr_data
);
   import pcfs_pkg::*;

   // configuration registers; the user writes them only while the block is idle, the block does not enforce it
   cfg_type  cfg_ff, cfg_in;

   // front to queue
   logic     q_push;
   qent_type q_wdata;
   // queue to back
   logic     q_pop;
   qent_type q_rdata;
   logic     q_full;
   logic     q_empty;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_RESET_CODE:  cfg_in.reset_code        = csr_data[3:0];
            CSR_SYNC_CODE:   cfg_in.sync_code         = csr_data[3:0];
            CSR_START_CODE:  cfg_in.start_code        = csr_data[3:0];
            CSR_RESET_DELAY: cfg_in.reset_delay_count = csr_data;
            CSR_SYNC_IDLE:   cfg_in.sync_idle_count   = csr_data;
            default:         cfg_in = cfg_ff;   // unknown index, no effect
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.reset_code        <= RESET_CODE_DEF;
         cfg_ff.sync_code         <= SYNC_CODE_DEF;
         cfg_ff.start_code        <= START_CODE_DEF;
         cfg_ff.reset_delay_count <= RESET_DELAY_DEF;
         cfg_ff.sync_idle_count   <= SYNC_IDLE_DEF;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // front: takes each transfer, tracks whether a frame is open, scales bytes
   pcfs_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_wdata   (q_wdata)
   );

   // short queue between classification and serialization
   pcfs_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .wdata (q_wdata),
      .pop   (q_pop),
      .rdata (q_rdata),
      .full  (q_full),
      .empty (q_empty)
   );

   // back: sequencer that expands each item into run-length symbols
   pcfs_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_rdata   (q_rdata),
      .q_empty   (q_empty),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // zero-length runs are skipped, so no symbol ever goes out with a zero count
   a_rep_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.repeat_res != '0))
      else $error("result with zero repeat count");

   // the frame's last symbol also closes the item that produced it
   a_fend_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.frame_end) |-> rsp_data.run_last)
      else $error("frame end without run last");

   // the back only takes work the queue actually holds
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty)
      else $error("queue popped while empty");

endmodule
`default_nettype wire

// File: rtl/pcfs_front.sv
`default_nettype none
module pcfs_front (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_valid,
   output logic                req_stall,
   input  pcfs_pkg::req_type   req_data,
   input  wire                 q_full,
   output logic                q_push,
   output pcfs_pkg::qent_type  q_wdata
);
   import pcfs_pkg::*;

   logic frame_active_ff, frame_active_in;
   logic accept;

   assign req_stall = q_full;
   assign accept    = req_valid && !req_stall;

   // bytes outside a frame are dropped here
   assign q_push = accept && (req_data.kind == KIND_START || frame_active_ff);

   always_comb begin
      q_wdata.is_start = (req_data.kind == KIND_START);
      q_wdata.do_reset = req_data.need_reset || frame_active_ff;
      q_wdata.value    = scale_level(req_data.level);
      q_wdata.last     = req_data.last_byte;
   end

   always_comb begin
      frame_active_in = frame_active_ff;
      if (accept) begin
         if (req_data.kind == KIND_START) begin
            frame_active_in = 1'b1;
         end else if (frame_active_ff && req_data.last_byte) begin
            frame_active_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_active_ff <= 1'b0;
      end else begin
         frame_active_ff <= frame_active_in;
      end
   end

endmodule
`default_nettype wire

// File: rtl/pcfs_queue.sv
`default_nettype none
module pcfs_queue (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 push,
   input  pcfs_pkg::qent_type  wdata,
   input  wire                 pop,
   output pcfs_pkg::qent_type  rdata,
   output logic                full,
   output logic                empty
);
   import pcfs_pkg::*;

   qent_type              mem_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CW-1:0]   count_ff, count_in;

   assign full  = (count_ff == QUEUE_CW'(QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign rdata = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule
`default_nettype wire

// File: rtl/pcfs_back.sv
`default_nettype none
module pcfs_back (
   input  wire                 clock,
   input  wire                 reset,
   input  pcfs_pkg::cfg_type   cfg,
   input  pcfs_pkg::qent_type  q_rdata,
   input  wire                 q_empty,
   output logic                q_pop,
   output logic                rsp_valid,
   input  wire                 rsp_stall,
   output pcfs_pkg::rsp_type   rsp_data
);
   import pcfs_pkg::*;

   typedef enum logic [11:0] {
      ST_IDLE     = 12'b0000_0000_0001,
      ST_RST_HDR  = 12'b0000_0000_0010,
      ST_RST_CMD  = 12'b0000_0000_0100,
      ST_RST_DLY  = 12'b0000_0000_1000,
      ST_SYN_HDR  = 12'b0000_0001_0000,
      ST_SYN_CMD  = 12'b0000_0010_0000,
      ST_SYN_ZERO = 12'b0000_0100_0000,
      ST_SYN_IDLE = 12'b0000_1000_0000,
      ST_STA_HDR  = 12'b0001_0000_0000,
      ST_STA_CMD  = 12'b0010_0000_0000,
      ST_LEAD     = 12'b0100_0000_0000,
      ST_BITS     = 12'b1000_0000_0000
   } state_type;

   state_type   state_ff, state_in;
   logic [3:0]  idx_ff, idx_in;
   logic [11:0] value_ff, value_in;
   logic        last_ff, last_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_data_ff, rsp_data_in;

   state_type   succ_state, first_state;
   logic [3:0]  succ_idx;
   logic [1:0]  sym;
   logic [11:0] rep;
   logic        fin, fend, emit, out_free;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign emit     = (state_ff != ST_IDLE) && out_free;
   assign q_pop    = !q_empty && ((state_ff == ST_IDLE) || (emit && fin));

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign first_state = q_rdata.is_start ? (q_rdata.do_reset ? ST_RST_HDR : ST_SYN_HDR)
                                         : ST_LEAD;

   // symbol for the current step and the step after it
   always_comb begin
      sym        = SYM_ZERO;
      rep        = ONE_RUN;
      fin        = 1'b0;
      fend       = 1'b0;
      succ_state = state_ff;
      succ_idx   = idx_ff - 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            succ_idx = idx_ff;
         end
         ST_RST_HDR: begin
            sym        = SYM_ONE;
            rep        = HDR_RUN;
            succ_state = ST_RST_CMD;
            succ_idx   = CMD_MSB;
         end
         ST_RST_CMD: begin
            sym = cfg.reset_code[idx_ff[1:0]] ? SYM_ONE : SYM_ZERO;
            if (idx_ff == '0) begin
               succ_state = (cfg.reset_delay_count != '0) ? ST_RST_DLY : ST_SYN_HDR;
            end
         end
         ST_RST_DLY: begin
            sym        = SYM_DELAY;
            rep        = cfg.reset_delay_count;
            succ_state = ST_SYN_HDR;
         end
         ST_SYN_HDR: begin
            sym        = SYM_ONE;
            rep        = HDR_RUN;
            succ_state = ST_SYN_CMD;
            succ_idx   = CMD_MSB;
         end
         ST_SYN_CMD: begin
            sym = cfg.sync_code[idx_ff[1:0]] ? SYM_ONE : SYM_ZERO;
            if (idx_ff == '0) begin
               succ_state = ST_SYN_ZERO;
            end
         end
         ST_SYN_ZERO: begin
            sym        = SYM_ZERO;
            rep        = HDR_RUN;
            succ_state = (cfg.sync_idle_count != '0) ? ST_SYN_IDLE : ST_STA_HDR;
         end
         ST_SYN_IDLE: begin
            sym        = SYM_IDLE;
            rep        = cfg.sync_idle_count;
            succ_state = ST_STA_HDR;
         end
         ST_STA_HDR: begin
            sym        = SYM_ONE;
            rep        = HDR_RUN;
            succ_state = ST_STA_CMD;
            succ_idx   = CMD_MSB;
         end
         ST_STA_CMD: begin
            sym = cfg.start_code[idx_ff[1:0]] ? SYM_ONE : SYM_ZERO;
            fin = (idx_ff == '0);
         end
         ST_LEAD: begin
            sym        = SYM_ZERO;
            succ_state = ST_BITS;
            succ_idx   = DATA_MSB;
         end
         ST_BITS: begin
            sym  = value_ff[idx_ff] ? SYM_ONE : SYM_ZERO;
            fin  = (idx_ff == '0);
            fend = fin && last_ff;
         end
         default: begin
            succ_state = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      value_in     = value_ff;
      last_in      = last_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (out_free) begin
         rsp_valid_in = emit;
      end
      if (emit) begin
         rsp_data_in.symbol     = sym;
         rsp_data_in.repeat_res = rep;
         rsp_data_in.run_last   = fin;
         rsp_data_in.frame_end  = fend;
         state_in               = fin ? ST_IDLE : succ_state;
         idx_in                 = succ_idx;
      end
      if (q_pop) begin
         state_in = first_state;
         value_in = q_rdata.value;
         last_in  = q_rdata.last;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      value_ff    <= value_in;
      last_ff     <= last_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule
`default_nettype wire
